// File: src/cpr_pkg.sv
`default_nettype none
package cpr_pkg;

	localparam logic [13:0] MAX_FRAME_BYTES    = 14'd16128;
	localparam logic [6:0]  CLASSIC_PACKET_MAX = 7'd8;
	localparam logic [6:0]  FD_PACKET_MAX      = 7'd64;

	localparam int unsigned CFG_INDEX_W = 1;
	localparam int unsigned CFG_DATA_W  = 14;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_FRAME_LENGTH = 1'b0,
		REG_FD_MODE      = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       first_byte;
		logic       last_byte;
		logic [6:0] packet_length;
	} cpr_item_t;

	typedef struct packed {
		logic        write_enable;
		logic [13:0] write_offset;
		logic [7:0]  write_byte;
		logic        frame_done;
		logic [31:0] lost_frame_count;
	} cpr_result_t;

endpackage
`default_nettype wire

// File: src/cpr_in_reg.sv
`default_nettype none
module cpr_in_reg (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      load,
	input  wire                      fire,
	input  wire cpr_pkg::cpr_item_t  item,
	output logic                     valid_s1,
	output cpr_pkg::cpr_item_t       item_s1
);
	import cpr_pkg::*;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= item;
		end
	end

endmodule
`default_nettype wire

// File: src/cpr_core.sv
`default_nettype none
module cpr_core (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 cfg_we,
	input  wire [cpr_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  wire [cpr_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  wire                                 fire,
	input  wire cpr_pkg::cpr_item_t             item,
	output cpr_pkg::cpr_result_t                result
);
	import cpr_pkg::*;

	logic [13:0] frame_length_q;
	logic        fd_mode_q;

	logic [13:0] fill_count_q;
	logic [7:0]  expected_index_q;
	logic [31:0] lost_total_q;
	logic        skipping_packet_q;
	logic        in_packet_q;

	logic [13:0] fill_n;
	logic [7:0]  exp_n;
	logic [31:0] lost_n;
	logic        skip_n;
	logic        in_n;

	logic [13:0] eff_len;
	logic [6:0]  pkt_limit;
	logic        bad_len;
	logic        mismatch;
	logic        stray_idx;
	logic [1:0]  lost_add;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_length_q <= 14'd1;
			fd_mode_q      <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_FRAME_LENGTH: frame_length_q <= cfg_data;
				REG_FD_MODE:      fd_mode_q      <= cfg_data[0];
				default:          ;
			endcase
		end
	end

	always_comb begin
		eff_len   = (frame_length_q > MAX_FRAME_BYTES) ? MAX_FRAME_BYTES : frame_length_q;
		pkt_limit = fd_mode_q ? FD_PACKET_MAX : CLASSIC_PACKET_MAX;
		bad_len   = (item.packet_length == 7'd0) || (item.packet_length > pkt_limit);
		mismatch  = item.byte_value != expected_index_q;
		stray_idx = mismatch && (item.byte_value != 8'd0);
		lost_add  = 2'd0;

		fill_n = fill_count_q;
		exp_n  = expected_index_q;
		skip_n = skipping_packet_q;
		in_n   = in_packet_q;

		result = '0;

		if (item.first_byte) begin
			in_n   = 1'b1;
			skip_n = 1'b0;
			if (bad_len) begin
				skip_n = 1'b1;
			end else begin
				if (mismatch) begin
					lost_add = {1'b0, fill_count_q != 14'd0} + {1'b0, stray_idx};
					fill_n   = 14'd0;
					exp_n    = 8'd0;
					skip_n   = stray_idx;
				end
				if (!skip_n && item.packet_length >= 7'd2) begin
					exp_n = exp_n + 8'd1;
				end
			end
		end else if (in_packet_q && !skipping_packet_q) begin
			if (fill_count_q < eff_len) begin
				result.write_enable = 1'b1;
				result.write_offset = fill_count_q;
				result.write_byte   = item.byte_value;
				fill_n              = fill_count_q + 14'd1;
			end
		end

		if (item.last_byte && in_n) begin
			if (!skip_n && fill_n >= eff_len) begin
				result.frame_done = 1'b1;
				fill_n            = 14'd0;
				exp_n             = 8'd0;
			end
			in_n   = 1'b0;
			skip_n = 1'b0;
		end

		lost_n                  = lost_total_q + {30'd0, lost_add};
		result.lost_frame_count = lost_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_count_q      <= '0;
			expected_index_q  <= '0;
			lost_total_q      <= '0;
			skipping_packet_q <= 1'b0;
			in_packet_q       <= 1'b0;
		end else if (fire) begin
			fill_count_q      <= fill_n;
			expected_index_q  <= exp_n;
			lost_total_q      <= lost_n;
			skipping_packet_q <= skip_n;
			in_packet_q       <= in_n;
		end
	end

endmodule
`default_nettype wire

// File: src/cpr_out_buf.sv
`default_nettype none
module cpr_out_buf (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        push,
	input  wire cpr_pkg::cpr_result_t  push_data,
	output logic                       ready,
	output logic                       out_valid,
	input  wire                        out_stall,
	output cpr_pkg::cpr_result_t       out_data
);
	import cpr_pkg::*;

	logic        main_valid_q;
	logic        skid_valid_q;
	cpr_result_t main_q;
	cpr_result_t skid_q;
	logic        pop;

	assign ready     = !skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_data  = main_q;
	assign pop       = main_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else if (!push) begin
				main_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (main_valid_q) begin
				skid_valid_q <= 1'b1;
			end else begin
				main_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				main_q <= skid_q;
			end else if (push) begin
				main_q <= push_data;
			end
		end else if (push) begin
			if (main_valid_q) begin
				skid_q <= push_data;
			end else begin
				main_q <= push_data;
			end
		end
	end

endmodule
`default_nettype wire

// File: src/can_packet_reassembler_top.sv
`default_nettype none
// Channel  | Handshake                 | Payload
// ---------+---------------------------+-------------------------------------------------
// in       | in_valid / in_stall       | byte_value, first_byte, last_byte, packet_length
// out      | out_valid / out_stall     | write_enable, write_offset, write_byte,
//          |                           | frame_done, lost_frame_count
// cfg      | cfg_we (no wait)          | cfg_index, cfg_data
//
// One transaction in gives one transaction out, one per clock when out is not stalled.
// The path runs through the input register, then the reassembly logic into the output register.
// The per-byte state update (fill, index, loss count) closes in that single stage.
// A two-entry output buffer (register plus skid) absorbs out_stall; in_stall rises only
// when both entries are full and the input register holds a transaction.
// Async reset clears state; frame_length resets to 1, fd_mode to classic.
module can_packet_reassembler_top (
	input  wire                                 clk,
	input  wire                                 arst_n,
	// configuration
	input  wire                                 cfg_we,
	input  wire [cpr_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  wire [cpr_pkg::CFG_DATA_W-1:0]       cfg_data,
	// input byte stream
	input  wire                                 in_valid,
	output logic                                in_stall,
	input  wire [7:0]                           byte_value,
	input  wire                                 first_byte,
	input  wire                                 last_byte,
	input  wire [6:0]                           packet_length,
	// buffer write stream
	output logic                                out_valid,
	input  wire                                 out_stall,
	output logic                                write_enable,
	output logic [13:0]                         write_offset,
	output logic [7:0]                          write_byte,
	output logic                                frame_done,
	output logic [31:0]                         lost_frame_count
);
	import cpr_pkg::*;

	cpr_item_t   item_in;
	cpr_item_t   item_s1;
	logic        valid_s1;
	logic        buf_ready;
	logic        fire;
	logic        load;
	cpr_result_t result;
	cpr_result_t out_data;

	assign item_in.byte_value    = byte_value;
	assign item_in.first_byte    = first_byte;
	assign item_in.last_byte     = last_byte;
	assign item_in.packet_length = packet_length;

	// stage 1 advances whenever the output buffer has a free slot
	assign fire     = valid_s1 && buf_ready;
	assign in_stall = valid_s1 && !buf_ready;
	assign load     = in_valid && !in_stall;

	cpr_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.fire     (fire),
		.item     (item_in),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	// config registers and reassembly state; state commits on fire
	cpr_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.fire      (fire),
		.item      (item_s1),
		.result    (result)
	);

	cpr_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fire),
		.push_data (result),
		.ready     (buf_ready),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	assign write_enable     = out_data.write_enable;
	assign write_offset     = out_data.write_offset;
	assign write_byte       = out_data.write_byte;
	assign frame_done       = out_data.frame_done;
	assign lost_frame_count = out_data.lost_frame_count;

endmodule
`default_nettype wire

// File: src/cpr_checker.sv
`default_nettype none
module cpr_checker (
	input wire                                 clk,
	input wire                                 arst_n,
	input wire                                 in_valid,
	input wire                                 in_stall,
	input wire                                 out_valid,
	input wire                                 out_stall,
	input wire                                 write_enable,
	input wire [13:0]                          write_offset,
	input wire [7:0]                           write_byte
);
	import cpr_pkg::*;

	// stalled result transaction stays presented
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("out_valid dropped while stalled");

	// no write means zeroed offset and data
	a_idle_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !write_enable |-> write_offset == 14'd0 && write_byte == 8'd0)
		else $error("offset or byte nonzero without write");

	// writes stay inside the largest frame
	a_offset_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && write_enable |-> write_offset < MAX_FRAME_BYTES)
		else $error("write offset beyond frame buffer");

	// nothing can stall the input unless a transaction was taken earlier
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall && !$past(in_stall) |-> $past(in_valid))
		else $error("input stalled with nothing accepted");

endmodule

bind can_packet_reassembler_top cpr_checker u_cpr_checker (.*);
`default_nettype wire
